@@ src/wsd_pkg.sv @@
// types and constants for the websocket frame deframer
// no dependencies; imported by websocket_frame_deframer
package wsd_pkg;

  // frame parse phase, one-hot
  typedef enum logic [7:0] {
    PH_HDR0    = 8'b0000_0001,
    PH_HDR1    = 8'b0000_0010,
    PH_EXT16   = 8'b0000_0100,
    PH_EXT64   = 8'b0000_1000,
    PH_KEY     = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_TAIL    = 8'b0100_0000,
    PH_CTRL    = 8'b1000_0000
  } phase_t;

  // control opcodes
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // last byte index of each multi-byte header field
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  // buffer status codes
  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_CLOSE     = 2'd1;
  localparam logic [1:0] ST_PING_PONG = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

endpackage

@@ src/websocket_frame_deframer.sv @@
// websocket frame deframer top level: header parse, unmasking, status
// depends on wsd_pkg
//
// Receive-side deframer for one websocket frame per buffer. Each input beat
// carries one byte of the buffer and a flag on the final byte. The block
// reads the opcode, mask bit and 7-bit length, the 16-bit or 64-bit
// big-endian extended length, and the 4-byte mask key when the mask bit is
// set. Payload bytes leave unmasked, one output beat per payload byte; bytes
// past the declared length are dropped. The final byte produces one output
// beat with out_done set and a status: data complete, close, ping or pong,
// or truncated (buffer ended inside the header, key or payload). On
// truncated the consumer must discard payload bytes it already took. FIN and
// RSV bits are not checked. Header bytes that are not last produce no beat.
// Throughput is one byte per clock while in_stall is low; the parse state
// updates on every accepted byte, and results are registered. A two-entry
// output (register plus skid stage) lets the input run while one result
// waits; in_stall rises only when both entries are full.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_byte,
  output logic [7:0] out_byte,
  output logic       out_done,
  output logic [1:0] out_status
);

  // parse state
  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask_on, mask_on_next;
  logic [2:0]  field_count, field_count_next;
  // extended length accumulator, then bytes of payload still to come
  logic [63:0] payload_length, payload_length_next;
  logic [31:0] mask_key, mask_key_next;
  // payload byte position mod 4, selects the key byte
  logic [1:0]  byte_index, byte_index_next;

  // skid stage
  logic        skid_valid;
  logic        skid_has_byte;
  logic [7:0]  skid_byte;
  logic        skid_done;
  logic [1:0]  skid_status;

  // result of the current beat
  logic        res_valid;
  logic        res_has_byte;
  logic [7:0]  res_byte;
  logic [1:0]  res_status;
  logic [7:0]  key_byte;
  logic [63:0] shifted_length;
  logic        is_ctrl;
  phase_t      len_done_phase;

  logic        in_fire;
  logic        out_pop;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;

  assign shifted_length = {payload_length[55:0], in_byte};
  assign is_ctrl = (opcode == OP_CLOSE) || (opcode == OP_PING) || (opcode == OP_PONG);

  // key byte for this payload position, first key byte in the top bits
  always_comb begin
    unique case (byte_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next          = phase;
    opcode_next         = opcode;
    mask_on_next        = mask_on;
    field_count_next    = field_count;
    payload_length_next = payload_length;
    mask_key_next       = mask_key;
    byte_index_next     = byte_index;
    res_has_byte        = 1'b0;
    res_byte            = 8'd0;
    len_done_phase      = PH_TAIL;

    unique case (phase)
      PH_HDR0: begin
        opcode_next = in_byte[3:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_next = in_byte[7];
        if (is_ctrl) begin
          phase_next = PH_CTRL;
        end else begin
          field_count_next = 3'd0;
          if (in_byte[6:0] == LEN_EXT16) begin
            phase_next          = PH_EXT16;
            payload_length_next = 64'd0;
          end else if (in_byte[6:0] == LEN_EXT64) begin
            phase_next          = PH_EXT64;
            payload_length_next = 64'd0;
          end else begin
            payload_length_next = {57'd0, in_byte[6:0]};
            byte_index_next     = 2'd0;
            if (in_byte[7]) begin
              phase_next = PH_KEY;
            end else if (in_byte[6:0] == 7'd0) begin
              phase_next = PH_TAIL;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        payload_length_next = shifted_length;
        if (field_count == ((phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
          field_count_next = 3'd0;
          byte_index_next  = 2'd0;
          if (mask_on) begin
            phase_next = PH_KEY;
          end else begin
            phase_next = (shifted_length == 64'd0) ? PH_TAIL : PH_PAYLOAD;
          end
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (field_count >= KEY_LAST) begin
          field_count_next = 3'd0;
          byte_index_next  = 2'd0;
          len_done_phase   = (payload_length == 64'd0) ? PH_TAIL : PH_PAYLOAD;
          phase_next       = len_done_phase;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        res_has_byte        = 1'b1;
        res_byte            = mask_on ? (in_byte ^ key_byte) : in_byte;
        byte_index_next     = byte_index + 2'd1;
        payload_length_next = payload_length - 64'd1;
        if (payload_length == 64'd1) begin
          phase_next = PH_TAIL;
        end
      end
      default: begin
        // tail and control frames: remaining bytes are ignored
      end
    endcase

    // status as seen after this byte
    if (phase_next == PH_CTRL) begin
      res_status = (opcode == OP_CLOSE) ? ST_CLOSE : ST_PING_PONG;
    end else if (phase_next == PH_TAIL) begin
      res_status = ST_DATA;
    end else begin
      res_status = ST_TRUNC;
    end
    if (!in_last) begin
      res_status = ST_DATA;
    end

    // the final byte returns everything to the reset state
    if (in_last) begin
      phase_next          = PH_HDR0;
      opcode_next         = 4'd0;
      mask_on_next        = 1'b0;
      field_count_next    = 3'd0;
      payload_length_next = 64'd0;
      mask_key_next       = 32'd0;
      byte_index_next     = 2'd0;
    end
  end

  assign res_valid = res_has_byte || in_last;

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      opcode         <= 4'd0;
      mask_on        <= 1'b0;
      field_count    <= 3'd0;
      payload_length <= 64'd0;
      mask_key       <= 32'd0;
      byte_index     <= 2'd0;
    end else if (in_fire) begin
      phase          <= phase_next;
      opcode         <= opcode_next;
      mask_on        <= mask_on_next;
      field_count    <= field_count_next;
      payload_length <= payload_length_next;
      mask_key       <= mask_key_next;
      byte_index     <= byte_index_next;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_fire && res_valid;
        end
      end else if (in_fire && res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_has_byte <= skid_has_byte;
        out_byte     <= skid_byte;
        out_done     <= skid_done;
        out_status   <= skid_status;
      end else begin
        out_has_byte <= res_has_byte;
        out_byte     <= res_byte;
        out_done     <= in_last;
        out_status   <= res_status;
      end
    end
    if (out_valid && !out_pop && !skid_valid) begin
      skid_has_byte <= res_has_byte;
      skid_byte     <= res_byte;
      skid_done     <= in_last;
      skid_status   <= res_status;
    end
  end

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with empty output register");

  // every output beat carries a byte or closes the buffer
  a_beat_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_has_byte || out_done))
    else $error("output beat with neither byte nor done");

  // status is zero unless the buffer closes
  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_done) |-> (out_status == ST_DATA))
    else $error("status set on a beat that does not close the buffer");

  // final byte returns the parser to the first header byte
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_last) |=> (phase == PH_HDR0))
    else $error("parser not back at header after final byte");

  // payload phase always has bytes left to take
  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_length != 64'd0))
    else $error("payload phase with nothing left");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for websocket_frame_deframer: directed and random frame buffers
// depends on wsd_pkg and the websocket_frame_deframer rtl
module tb_top
  import wsd_pkg::*;
();

  // idle stretch of cycles before a hang is declared
  localparam int WATCHDOG_LIMIT = 5000;
  // receiver hold-off length for the backpressure test
  localparam int HOLD_OFF_CYCLES = 400;
  // quiet cycles after the last expected beat has come out
  localparam int DRAIN_TAIL = 20;
  // declared lengths above this get a short random body instead
  localparam int BODY_CAP = 300;

  typedef logic [7:0] byte_q_t[$];

  // one output beat as the block should present it
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       done;
    logic [1:0] status;
  } deframed_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_has_byte;
  logic [7:0] out_byte;
  logic       out_done;
  logic [1:0] out_status;

  // idle percentages of sender and receiver, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // set by the backpressure test, cleared by the stall process when it starts the hold
  bit hold_off_go = 1'b0;
  int hold_off_left = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;

  deframed_beat_t deframed_q[$];

  // mirror of the deframer parse state
  phase_t      rx_phase = PH_HDR0;
  logic [3:0]  rx_opcode = '0;
  logic        rx_masked = 1'b0;
  logic [2:0]  rx_field_idx = '0;
  logic [63:0] rx_length = '0;
  logic [31:0] rx_key = '0;
  logic [63:0] rx_offset = '0;

  websocket_frame_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_has_byte (out_has_byte),
    .out_byte     (out_byte),
    .out_done     (out_done),
    .out_status   (out_status)
  );

  always #5 clk = ~clk;

  function automatic bit is_control_op(input logic [3:0] op);
    return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

  // header done: go to payload, or straight to the tail when the payload is empty
  function automatic void enter_body();
    rx_phase  = (rx_length == 64'd0) ? PH_TAIL : PH_PAYLOAD;
    rx_offset = '0;
  endfunction

  // length known: the mask key comes next if the mask bit was set
  function automatic void length_known();
    rx_field_idx = '0;
    if (rx_masked) begin
      rx_phase = PH_KEY;
    end else begin
      enter_body();
    end
  endfunction

  // advance the mirrored parser by one byte; returns 1 when the byte yields an output beat
  function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                      output deframed_beat_t beat);
    logic       has;
    logic [7:0] ob;
    has  = 1'b0;
    ob   = 8'h00;
    beat = '0;
    case (rx_phase)
      PH_HDR0: begin
        rx_opcode = b[3:0];
        rx_phase  = PH_HDR1;
      end
      PH_HDR1: begin
        rx_masked = b[7];
        if (is_control_op(rx_opcode)) begin
          // rest of a control frame is skipped
          rx_phase = PH_CTRL;
        end else begin
          rx_field_idx = '0;
          rx_length    = '0;
          if (b[6:0] == LEN_EXT16) begin
            rx_phase = PH_EXT16;
          end else if (b[6:0] == LEN_EXT64) begin
            rx_phase = PH_EXT64;
          end else begin
            rx_length = {57'd0, b[6:0]};
            length_known();
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        // big-endian extended length
        rx_length = {rx_length[55:0], b};
        if (rx_field_idx == ((rx_phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
          length_known();
        end else begin
          rx_field_idx = rx_field_idx + 3'd1;
        end
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], b};
        if (rx_field_idx >= KEY_LAST) begin
          rx_field_idx = '0;
          enter_body();
        end else begin
          rx_field_idx = rx_field_idx + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        // first key byte sits in the top bits and masks offset 0
        ob  = rx_masked ? (b ^ rx_key[8 * (3 - rx_offset[1:0]) +: 8]) : b;
        has = 1'b1;
        rx_offset = rx_offset + 64'd1;
        if (rx_offset >= rx_length) begin
          rx_phase = PH_TAIL;
        end
      end
      default: begin
        // tail and control: bytes are ignored
      end
    endcase
    if (!has && !last) begin
      return 1'b0;
    end
    beat.has_byte = has;
    beat.data     = ob;
    beat.done     = last;
    beat.status   = ST_DATA;
    if (last) begin
      if (rx_phase == PH_CTRL) begin
        beat.status = (rx_opcode == OP_CLOSE) ? ST_CLOSE : ST_PING_PONG;
      end else if (rx_phase == PH_TAIL) begin
        beat.status = ST_DATA;
      end else begin
        beat.status = ST_TRUNC;
      end
      // the last byte always returns the parser to its reset state
      rx_phase     = PH_HDR0;
      rx_opcode    = '0;
      rx_masked    = 1'b0;
      rx_field_idx = '0;
      rx_length    = '0;
      rx_key       = '0;
      rx_offset    = '0;
    end
    return 1'b1;
  endfunction

  // offer one byte, hold it until accepted, then record what it should produce;
  // valid is left high so back-to-back beats never lower and raise it in one step
  task automatic send_beat(input logic [7:0] b, input logic last);
    deframed_beat_t beat;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (deframe_byte(b, last, beat)) begin
      deframed_q.insert(deframed_q.size(), beat);
    end
  endtask

  // one receive buffer, in_last on its final byte
  task automatic send_buffer(input byte_q_t bytes);
    for (int i = 0; i < bytes.size(); i++) begin
      send_beat(bytes[i], i == bytes.size() - 1);
    end
  endtask

  // stop offering and wait until every expected beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // build one random buffer: mostly well-formed data frames, some control
  // frames, some noise and some cut short anywhere in header, key or payload
  task automatic send_random_frame(output int beats_sent);
    byte_q_t     bytes;
    int          kind;
    int          pick;
    int          body;
    int          cut;
    logic [3:0]  op;
    logic        masked;
    logic [63:0] len;
    bytes  = {};
    kind   = $urandom_range(99);
    masked = 1'($urandom_range(1));
    if (kind < 5) begin
      // noise of any bytes at all
      repeat ($urandom_range(1, 6)) bytes.insert(bytes.size(), 8'($urandom));
    end else if (kind < 17) begin
      case ($urandom_range(2))
        0:       op = OP_CLOSE;
        1:       op = OP_PING;
        default: op = OP_PONG;
      endcase
      bytes.insert(bytes.size(), {4'($urandom), op});
      bytes.insert(bytes.size(), 8'($urandom));
      repeat ($urandom_range(0, 4)) bytes.insert(bytes.size(), 8'($urandom));
    end else begin
      op = 4'($urandom);
      while (is_control_op(op)) op = 4'($urandom);
      // fin and rsv bits random, the block ignores them
      bytes.insert(bytes.size(), {4'($urandom), op});
      pick = $urandom_range(99);
      if (pick < 75) begin
        len = (pick < 68) ? 64'($urandom_range(0, 24)) : 64'($urandom_range(25, 125));
        bytes.insert(bytes.size(), {masked, len[6:0]});
      end else if (pick < 88) begin
        len = ($urandom_range(9) == 0) ? 64'($urandom_range(0, 65535))
                                       : 64'($urandom_range(0, 60));
        bytes.insert(bytes.size(), {masked, LEN_EXT16});
        bytes.insert(bytes.size(), len[15:8]);
        bytes.insert(bytes.size(), len[7:0]);
      end else begin
        len = ($urandom_range(4) == 0) ? {32'($urandom), 32'($urandom)}
                                       : 64'($urandom_range(0, 40));
        bytes.insert(bytes.size(), {masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) bytes.insert(bytes.size(), len[8 * i +: 8]);
      end
      if (masked) begin
        repeat (4) bytes.insert(bytes.size(), 8'($urandom));
      end
      // huge declared lengths get a short body and end truncated
      body = (len > 64'(BODY_CAP)) ? $urandom_range(0, 40) : int'(len);
      repeat (body) bytes.insert(bytes.size(), 8'($urandom));
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) bytes.insert(bytes.size(), 8'($urandom));
      end
      if (kind >= 85) begin
        cut   = $urandom_range(1, bytes.size());
        bytes = bytes[0:cut-1];
      end
    end
    send_buffer(bytes);
    beats_sent = bytes.size();
  endtask

  // extremes and special cases of the header parse, one buffer each
  task automatic test_directed_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_buffer('{8'h81});                                   // buffer ends in first byte
    send_buffer('{8'h88, 8'h80});                            // close
    send_buffer('{8'h89, 8'h05, 8'hAA});                     // ping, rest ignored
    send_buffer('{8'h0A, 8'hFF});                            // pong, full second byte
    send_buffer('{8'h70, 8'h00});                            // rsv set, empty payload
    // masked two-byte payload followed by an excess byte
    send_buffer('{8'h8F, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h11});
    send_buffer('{8'h82, 8'h7E, 8'h00});                     // ends inside 16-bit length
    send_buffer('{8'h02, 8'h03, 8'h41});                     // ends inside payload
    send_buffer('{8'h82, 8'h80});                            // ends before mask key
    wait_drained();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct,
                                    input int beat_target);
    int sent;
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < beat_target) begin
      send_random_frame(n);
      sent += n;
    end
    wait_drained();
  endtask

  // receiver holds off for a long stretch while long payloads keep coming,
  // so the output stages fill and the input must stall
  task automatic test_output_holdoff();
    byte_q_t bytes;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_go   = 1'b1;
    repeat (2) begin
      bytes = '{8'h82, 8'd120};
      repeat (120) bytes.insert(bytes.size(), 8'($urandom));
      send_buffer(bytes);
    end
    wait_drained();
  endtask

  // receiver stall: a counted hold-off when requested, random otherwise
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_go) begin
      hold_off_go   = 1'b0;
      out_stall     <= 1'b1;
      hold_off_left <= HOLD_OFF_CYCLES - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted output beat with the oldest expectation
  always @(posedge clk) begin
    deframed_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected beat: has=%0b byte=%02h done=%0b status=%0d",
                   out_has_byte, out_byte, out_done, out_status);
        end
      end else begin
        want = deframed_q.pop_front();
        if (out_has_byte !== want.has_byte || out_byte !== want.data ||
            out_done !== want.done || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp has=%0b byte=%02h done=%0b status=%0d",
                     want.has_byte, want.data, want.done, want.status);
            $display("          got has=%0b byte=%02h done=%0b status=%0d",
                     out_has_byte, out_byte, out_done, out_status);
          end
        end
      end
    end
  end

  // hang detection: no beat accepted on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_random_frames(35, 77, 620);
    test_random_frames(77, 35, 620);
    test_random_frames(0, 0, 470);
    test_output_holdoff();
    // anything still queued never came out
    if (deframed_q.size() != 0) begin
      $display("%0d expected beats never arrived", deframed_q.size());
      mismatch_count += deframed_q.size();
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
